[rtl/priority_ready_queue_scheduler_assert.svh]
// Assertion macros used by the checker file.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define PRQS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define PRQS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/prqs_pkg.sv]
`default_nettype none
package prqs_pkg;

  localparam int NUM_TASKS     = 16;
  localparam int NUM_LEVELS    = 4;
  localparam int NUM_STATES    = 6;
  localparam int NUM_QUEUES    = NUM_STATES * NUM_LEVELS;
  localparam int DEFAULT_LEVEL = (NUM_LEVELS - 1) < 3 ? (NUM_LEVELS - 1) : 3;

  localparam int MODE_W = 3;
  localparam int PID_W  = 4;
  localparam int ST_W   = 3;
  localparam int LVL_W  = 3;
  localparam int Q_W    = $clog2(NUM_QUEUES);

  // Process states
  localparam logic [ST_W-1:0] ST_NEW   = ST_W'(0);
  localparam logic [ST_W-1:0] ST_READY = ST_W'(1);
  localparam logic [ST_W-1:0] ST_RUN   = ST_W'(2);
  localparam logic [ST_W-1:0] ST_BLK0  = ST_W'(3);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADMIT     = 3'd0,
    MODE_BLOCK     = 3'd1,
    MODE_UNBLK_BST = 3'd2,
    MODE_UNBLK_PID = 3'd3,
    MODE_YIELD     = 3'd4,
    MODE_SET_PRIO  = 3'd5,
    MODE_READ_PRIO = 3'd6
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_UB2, S_UP2, S_SP2, S_CHK, S_REL1, S_REL2, S_RESP
  } fsm_e;

  typedef enum logic [3:0] {
    U_NONE, U_LATCH, U_ERR, U_ADMIT, U_BLOCK, U_UB_POP, U_UB_PUSH, U_UP_UNLINK,
    U_UP_PUSH, U_SP_UNLINK, U_SP_PUSH, U_SP_SET, U_READ, U_REQUEUE, U_PICK
  } uop_e;

  typedef enum logic [1:0] {Q_NONE, Q_PUSH, Q_POP, Q_UNLINK} qop_e;

  typedef struct packed {
    uop_e uop;
  } ctrl_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              err;
    logic              ub_empty;
    logic              pre;
    logic              up_skip;
    logic              up_urgent;
    logic              sp_nop;
    logic              sp_move;
    logic              beats;
  } stat_t;

  function automatic logic [Q_W-1:0] qid(input logic [ST_W-1:0] s,
                                         input logic [LVL_W-1:0] l);
    int q;
    q = int'(s) * NUM_LEVELS + int'(l);
    if (int'(s) >= NUM_STATES || int'(l) >= NUM_LEVELS) q = 0;
    return Q_W'(q);
  endfunction

endpackage
`default_nettype wire

[rtl/priority_ready_queue_scheduler.sv]
// The command sequencer steps from the start transfer to the result strobe on done_o,
// with at most one queue link update per step (preemption adds two steps: requeue,
// then pick). A new command is taken only when idle; busy stays high until the result
// strobe.
// The result is shown for one cycle on done_o; the receiver cannot stall.
// Reset: asynchronous, active low; idle process runs, all processes new, queues empty.
`default_nettype none
module priority_ready_queue_scheduler (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [prqs_pkg::MODE_W-1:0] mode_i,
  input  wire logic [prqs_pkg::PID_W-1:0]  pid_i,
  input  wire logic [prqs_pkg::ST_W-1:0]   target_state_i,
  input  wire logic [prqs_pkg::LVL_W-1:0]  level_i,
  output logic                             done_o,
  output logic [prqs_pkg::PID_W-1:0]       running_pid_o,
  output logic                             status_o,
  output logic [prqs_pkg::LVL_W-1:0]       read_level_o,
  output logic                             switched_o
);

  prqs_pkg::ctrl_t ctrl;
  prqs_pkg::stat_t stat;

  prqs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  prqs_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_i),
    .pid_i          (pid_i),
    .target_state_i (target_state_i),
    .level_i        (level_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .running_pid_o  (running_pid_o),
    .status_o       (status_o),
    .read_level_o   (read_level_o),
    .switched_o     (switched_o)
  );

endmodule
`default_nettype wire

[rtl/prqs_ctrl.sv]
`default_nettype none
module prqs_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  output logic                done_o,
  input  wire prqs_pkg::stat_t stat_i,
  output prqs_pkg::ctrl_t     ctrl_o
);

  prqs_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prqs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prqs_pkg::S_IDLE: if (start) state_d = prqs_pkg::S_EXEC;
      prqs_pkg::S_EXEC: begin
        if (stat_i.err) begin
          state_d = prqs_pkg::S_RESP;
        end else begin
          unique case (stat_i.mode)
            prqs_pkg::MODE_ADMIT:     state_d = prqs_pkg::S_CHK;
            prqs_pkg::MODE_BLOCK:     state_d = prqs_pkg::S_REL2;
            prqs_pkg::MODE_UNBLK_BST:
              state_d = stat_i.ub_empty ? prqs_pkg::S_RESP : prqs_pkg::S_UB2;
            prqs_pkg::MODE_UNBLK_PID:
              state_d = stat_i.up_skip ? prqs_pkg::S_RESP : prqs_pkg::S_UP2;
            prqs_pkg::MODE_YIELD:     state_d = prqs_pkg::S_REL2;
            prqs_pkg::MODE_SET_PRIO: begin
              if (stat_i.sp_nop)       state_d = prqs_pkg::S_RESP;
              else if (stat_i.sp_move) state_d = prqs_pkg::S_SP2;
              else                     state_d = prqs_pkg::S_CHK;
            end
            default:                  state_d = prqs_pkg::S_RESP;
          endcase
        end
      end
      prqs_pkg::S_UB2:  state_d = stat_i.pre ? prqs_pkg::S_REL1 : prqs_pkg::S_RESP;
      prqs_pkg::S_UP2:  state_d = stat_i.up_urgent ? prqs_pkg::S_REL1 : prqs_pkg::S_RESP;
      prqs_pkg::S_SP2:  state_d = prqs_pkg::S_CHK;
      prqs_pkg::S_CHK:  state_d = stat_i.beats ? prqs_pkg::S_REL1 : prqs_pkg::S_RESP;
      prqs_pkg::S_REL1: state_d = prqs_pkg::S_REL2;
      prqs_pkg::S_REL2: state_d = prqs_pkg::S_RESP;
      prqs_pkg::S_RESP: state_d = prqs_pkg::S_IDLE;
      default:          state_d = prqs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.uop = prqs_pkg::U_NONE;
    busy       = (state_q != prqs_pkg::S_IDLE);
    done_o     = 1'b0;
    unique case (state_q)
      prqs_pkg::S_IDLE: if (start) ctrl_o.uop = prqs_pkg::U_LATCH;
      prqs_pkg::S_EXEC: begin
        if (stat_i.err) begin
          ctrl_o.uop = prqs_pkg::U_ERR;
        end else begin
          unique case (stat_i.mode)
            prqs_pkg::MODE_ADMIT:     ctrl_o.uop = prqs_pkg::U_ADMIT;
            prqs_pkg::MODE_BLOCK:     ctrl_o.uop = prqs_pkg::U_BLOCK;
            prqs_pkg::MODE_UNBLK_BST:
              if (!stat_i.ub_empty) ctrl_o.uop = prqs_pkg::U_UB_POP;
            prqs_pkg::MODE_UNBLK_PID:
              if (!stat_i.up_skip) ctrl_o.uop = prqs_pkg::U_UP_UNLINK;
            prqs_pkg::MODE_YIELD:     ctrl_o.uop = prqs_pkg::U_REQUEUE;
            prqs_pkg::MODE_SET_PRIO: begin
              if (stat_i.sp_nop)       ctrl_o.uop = prqs_pkg::U_NONE;
              else if (stat_i.sp_move) ctrl_o.uop = prqs_pkg::U_SP_UNLINK;
              else                     ctrl_o.uop = prqs_pkg::U_SP_SET;
            end
            prqs_pkg::MODE_READ_PRIO: ctrl_o.uop = prqs_pkg::U_READ;
            default:                  ctrl_o.uop = prqs_pkg::U_NONE;
          endcase
        end
      end
      prqs_pkg::S_UB2:  ctrl_o.uop = prqs_pkg::U_UB_PUSH;
      prqs_pkg::S_UP2:  ctrl_o.uop = prqs_pkg::U_UP_PUSH;
      prqs_pkg::S_SP2:  ctrl_o.uop = prqs_pkg::U_SP_PUSH;
      prqs_pkg::S_CHK:  ctrl_o.uop = prqs_pkg::U_NONE;
      prqs_pkg::S_REL1: ctrl_o.uop = prqs_pkg::U_REQUEUE;
      prqs_pkg::S_REL2: ctrl_o.uop = prqs_pkg::U_PICK;
      prqs_pkg::S_RESP: done_o     = 1'b1;
      default:          ctrl_o.uop = prqs_pkg::U_NONE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/prqs_dpath.sv]
`default_nettype none
module prqs_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [prqs_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [prqs_pkg::PID_W-1:0]    pid_i,
  input  wire logic [prqs_pkg::ST_W-1:0]     target_state_i,
  input  wire logic [prqs_pkg::LVL_W-1:0]    level_i,
  input  wire prqs_pkg::ctrl_t               ctrl_i,
  output prqs_pkg::stat_t                    stat_o,
  output logic [prqs_pkg::PID_W-1:0]         running_pid_o,
  output logic                               status_o,
  output logic [prqs_pkg::LVL_W-1:0]         read_level_o,
  output logic                               switched_o
);

  localparam int NT = prqs_pkg::NUM_TASKS;
  localparam int NL = prqs_pkg::NUM_LEVELS;
  localparam int NQ = prqs_pkg::NUM_QUEUES;
  localparam int PW = prqs_pkg::PID_W;
  localparam int SW = prqs_pkg::ST_W;
  localparam int LW = prqs_pkg::LVL_W;
  localparam int QW = prqs_pkg::Q_W;

  // Latched command
  logic [prqs_pkg::MODE_W-1:0] mode_q;
  logic [PW-1:0] pid_q, mv_q, before_q;
  logic [SW-1:0] ts_q;
  logic [LW-1:0] lv_q, rd_q;
  logic          status_q, pre_q;

  logic [PW-1:0] running_q;
  logic [SW-1:0] pstate_q [NT];
  logic [LW-1:0] plevel_q [NT];
  logic [NQ-1:0] ne_q;
  // Links and queue ends are undefined until written
  logic [PW-1:0] older_q  [NT];
  logic [PW-1:0] newer_q  [NT];
  logic [PW-1:0] oldest_q [NQ];
  logic [PW-1:0] newest_q [NQ];

  logic          blocked_ts, pid_ok, user_ok, lv_ok;
  logic [LW-1:0] lvl_cur, lvl_pid, lvl_mv;
  logic [SW-1:0] st_pid;
  logic [NL-1:0] ts_ne, rdy_ne;
  logic [LW-1:0] ts_best, rdy_best;
  logic          ts_any, rdy_any, pre, beats;

  prqs_pkg::qop_e q_op;
  logic [QW-1:0]  q_idx;
  logic [PW-1:0]  q_pid;
  logic           q_ne;
  logic [PW-1:0]  q_old, q_new, u_o, u_n, pop_nxt;

  assign lvl_cur = plevel_q[running_q];
  assign lvl_pid = plevel_q[pid_q];
  assign lvl_mv  = plevel_q[mv_q];
  assign st_pid  = pstate_q[pid_q];

  assign blocked_ts = (ts_q >= prqs_pkg::ST_BLK0) && (int'(ts_q) < prqs_pkg::NUM_STATES);
  assign pid_ok     = int'(pid_q) < NT;
  assign user_ok    = pid_ok && (pid_q != '0);
  assign lv_ok      = int'(lv_q) < NL;

  always_comb begin
    ts_best  = '0;
    rdy_best = '0;
    pre      = 1'b0;
    beats    = 1'b0;
    for (int l = 0; l < NL; l++) begin
      ts_ne[l]  = blocked_ts && ne_q[prqs_pkg::qid(ts_q, LW'(l))];
      rdy_ne[l] = ne_q[prqs_pkg::qid(prqs_pkg::ST_READY, LW'(l))];
      if (ts_ne[l] && LW'(l) < lvl_cur)  pre   = 1'b1;
      if (rdy_ne[l] && LW'(l) < lvl_cur) beats = 1'b1;
    end
    for (int l = NL - 1; l >= 0; l--) begin
      if (ts_ne[l])  ts_best  = LW'(l);
      if (rdy_ne[l]) rdy_best = LW'(l);
    end
  end
  assign ts_any  = |ts_ne;
  assign rdy_any = |rdy_ne;

  always_comb begin
    stat_o.mode      = mode_q;
    stat_o.ub_empty  = !ts_any;
    stat_o.pre       = pre_q;
    stat_o.up_skip   = (st_pid != ts_q);
    stat_o.up_urgent = lvl_pid < lvl_cur;
    stat_o.sp_nop    = (pid_q == '0) && (int'(lv_q) == NL);
    stat_o.sp_move   = (pid_q != running_q) && (st_pid != prqs_pkg::ST_NEW) &&
                       (st_pid != prqs_pkg::ST_RUN);
    stat_o.beats     = beats;
    unique case (mode_q)
      prqs_pkg::MODE_ADMIT:
        stat_o.err = !user_ok || !lv_ok || (st_pid != prqs_pkg::ST_NEW);
      prqs_pkg::MODE_BLOCK:     stat_o.err = (running_q == '0) || !blocked_ts;
      prqs_pkg::MODE_UNBLK_BST: stat_o.err = !blocked_ts;
      prqs_pkg::MODE_UNBLK_PID: stat_o.err = !user_ok || !blocked_ts;
      prqs_pkg::MODE_YIELD:     stat_o.err = 1'b0;
      prqs_pkg::MODE_SET_PRIO:  stat_o.err = !stat_o.sp_nop && (!user_ok || !lv_ok);
      prqs_pkg::MODE_READ_PRIO: stat_o.err = !pid_ok;
      default:                  stat_o.err = 1'b1;
    endcase
  end

  // One queue primitive per cycle
  always_comb begin
    q_op  = prqs_pkg::Q_NONE;
    q_idx = '0;
    q_pid = pid_q;
    unique case (ctrl_i.uop)
      prqs_pkg::U_ADMIT: begin
        q_op  = prqs_pkg::Q_PUSH;
        q_idx = prqs_pkg::qid(prqs_pkg::ST_READY, lv_q);
      end
      prqs_pkg::U_BLOCK: begin
        q_op  = prqs_pkg::Q_PUSH;
        q_idx = prqs_pkg::qid(ts_q, lvl_cur);
        q_pid = running_q;
      end
      prqs_pkg::U_UB_POP: begin
        q_op  = prqs_pkg::Q_POP;
        q_idx = prqs_pkg::qid(ts_q, ts_best);
      end
      prqs_pkg::U_UB_PUSH: begin
        q_op  = prqs_pkg::Q_PUSH;
        q_idx = prqs_pkg::qid(prqs_pkg::ST_READY, lvl_mv);
        q_pid = mv_q;
      end
      prqs_pkg::U_UP_UNLINK: begin
        q_op  = prqs_pkg::Q_UNLINK;
        q_idx = prqs_pkg::qid(ts_q, lvl_pid);
      end
      prqs_pkg::U_UP_PUSH: begin
        q_op  = prqs_pkg::Q_PUSH;
        q_idx = prqs_pkg::qid(prqs_pkg::ST_READY, lvl_pid);
      end
      prqs_pkg::U_SP_UNLINK: begin
        q_op  = prqs_pkg::Q_UNLINK;
        q_idx = prqs_pkg::qid(st_pid, lvl_pid);
      end
      prqs_pkg::U_SP_PUSH: begin
        q_op  = prqs_pkg::Q_PUSH;
        q_idx = prqs_pkg::qid(st_pid, lv_q);
      end
      prqs_pkg::U_REQUEUE: begin
        if (running_q != '0) q_op = prqs_pkg::Q_PUSH;
        q_idx = prqs_pkg::qid(prqs_pkg::ST_READY, lvl_cur);
        q_pid = running_q;
      end
      prqs_pkg::U_PICK: begin
        if (rdy_any) q_op = prqs_pkg::Q_POP;
        q_idx = prqs_pkg::qid(prqs_pkg::ST_READY, rdy_best);
      end
      default: q_op = prqs_pkg::Q_NONE;
    endcase
  end

  assign q_ne    = ne_q[q_idx];
  assign q_old   = oldest_q[q_idx];
  assign q_new   = newest_q[q_idx];
  assign u_o     = older_q[q_pid];
  assign u_n     = newer_q[q_pid];
  assign pop_nxt = newer_q[q_old];

  always_ff @(posedge clk_i) begin
    unique case (q_op)
      prqs_pkg::Q_PUSH: begin
        if (q_ne) begin
          newer_q[q_new] <= q_pid;
          older_q[q_pid] <= q_new;
        end else begin
          oldest_q[q_idx] <= q_pid;
        end
        newest_q[q_idx] <= q_pid;
      end
      prqs_pkg::Q_POP: if (q_new != q_old) oldest_q[q_idx] <= pop_nxt;
      prqs_pkg::Q_UNLINK: begin
        if (q_ne) begin
          priority if (q_old == q_pid && q_new == q_pid) begin
          end else if (q_old == q_pid) begin
            oldest_q[q_idx] <= u_n;
          end else if (q_new == q_pid) begin
            newest_q[q_idx] <= u_o;
          end else begin
            newer_q[u_o] <= u_n;
            older_q[u_n] <= u_o;
          end
        end
      end
      default: ;
    endcase

    unique case (ctrl_i.uop)
      prqs_pkg::U_LATCH: begin
        mode_q   <= mode_i;
        pid_q    <= pid_i;
        ts_q     <= target_state_i;
        lv_q     <= level_i;
        before_q <= running_q;
        status_q <= 1'b0;
        rd_q     <= '0;
      end
      prqs_pkg::U_ERR:    status_q <= 1'b1;
      prqs_pkg::U_READ:   rd_q     <= lvl_pid;
      prqs_pkg::U_UB_POP: begin
        mv_q  <= q_old;
        pre_q <= pre;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      ne_q      <= '0;
      for (int i = 0; i < NT; i++) begin
        pstate_q[i] <= prqs_pkg::ST_NEW;
        plevel_q[i] <= (i == 0) ? LW'(NL) : LW'(prqs_pkg::DEFAULT_LEVEL);
      end
    end else begin
      unique case (q_op)
        prqs_pkg::Q_PUSH: ne_q[q_idx] <= 1'b1;
        prqs_pkg::Q_POP:  if (q_new == q_old) ne_q[q_idx] <= 1'b0;
        prqs_pkg::Q_UNLINK:
          if (q_ne && q_old == q_pid && q_new == q_pid) ne_q[q_idx] <= 1'b0;
        default: ;
      endcase
      unique case (ctrl_i.uop)
        prqs_pkg::U_ADMIT: begin
          plevel_q[pid_q] <= lv_q;
          pstate_q[pid_q] <= prqs_pkg::ST_READY;
        end
        prqs_pkg::U_BLOCK:   pstate_q[running_q] <= ts_q;
        prqs_pkg::U_UB_PUSH: pstate_q[mv_q]      <= prqs_pkg::ST_READY;
        prqs_pkg::U_UP_PUSH: pstate_q[pid_q]     <= prqs_pkg::ST_READY;
        prqs_pkg::U_SP_PUSH: plevel_q[pid_q]     <= lv_q;
        prqs_pkg::U_SP_SET:  plevel_q[pid_q]     <= lv_q;
        prqs_pkg::U_REQUEUE:
          if (running_q != '0) pstate_q[running_q] <= prqs_pkg::ST_READY;
        prqs_pkg::U_PICK: begin
          // Idle runs when no ready queue holds a process
          if (rdy_any) begin
            running_q       <= q_old;
            pstate_q[q_old] <= prqs_pkg::ST_RUN;
          end else begin
            running_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign running_pid_o = running_q;
  assign status_o      = status_q;
  assign read_level_o  = rd_q;
  assign switched_o    = (running_q != before_q);

endmodule
`default_nettype wire

[rtl/prqs_checker.sv]
`default_nettype none
`include "priority_ready_queue_scheduler_assert.svh"
module prqs_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done_o,
  input wire logic                        status_o,
  input wire logic                        switched_o,
  input wire logic [prqs_pkg::LVL_W-1:0]  read_level_o
);

  `PRQS_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `PRQS_ASSERT_IMP(a_done_busy, done_o, busy)
  `PRQS_ASSERT_NXT(a_done_single, done_o, !done_o && !busy)
  `PRQS_ASSERT_IMP(a_err_no_switch, done_o && status_o, !switched_o && read_level_o == '0)

endmodule

bind priority_ready_queue_scheduler prqs_checker u_prqs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .switched_o   (switched_o),
  .read_level_o (read_level_o)
);
`default_nettype wire

[tb/tb_priority_ready_queue_scheduler.sv]
`default_nettype none
module tb_priority_ready_queue_scheduler;
  import prqs_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [PID_W-1:0] running_pid;
    logic             status;
    logic [LVL_W-1:0] read_level;
    logic             switched;
  } sched_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [MODE_W-1:0]   mode_i = '0;
  logic [PID_W-1:0]    pid_i = '0;
  logic [ST_W-1:0]     target_state_i = '0;
  logic [LVL_W-1:0]    level_i = '0;
  logic                done_o;
  logic [PID_W-1:0]    running_pid_o;
  logic                status_o;
  logic [LVL_W-1:0]    read_level_o;
  logic                switched_o;

  sched_result_t expected_results[$];
  int  n_errors = 0;
  int  stall_cycles = 0;
  bit  idling_on = 1'b1;

  // scheduler shadow state
  logic [ST_W-1:0]  proc_st[NUM_TASKS];
  logic [LVL_W-1:0] proc_lv[NUM_TASKS];
  logic [PID_W-1:0] nxt_older[NUM_TASKS];
  logic [PID_W-1:0] nxt_newer[NUM_TASKS];
  logic [PID_W-1:0] q_head[NUM_QUEUES];
  logic [PID_W-1:0] q_tail[NUM_QUEUES];
  bit               q_full[NUM_QUEUES];
  logic [PID_W-1:0] cur_pid;

  priority_ready_queue_scheduler i_dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .pid_i, .target_state_i, .level_i,
    .done_o, .running_pid_o, .status_o, .read_level_o, .switched_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int queue_of(int s, int l);
    if (s >= NUM_STATES || l >= NUM_LEVELS) return 0;
    return s * NUM_LEVELS + l;
  endfunction

  function automatic bit is_blocked_kind(int s);
    return s >= 3 && s < NUM_STATES;
  endfunction

  function automatic void enqueue(int q, int p);
    if (q_full[q]) begin
      nxt_newer[q_tail[q]] = PID_W'(p);
      nxt_older[p] = q_tail[q];
    end else begin
      q_head[q] = PID_W'(p);
      q_full[q] = 1'b1;
    end
    q_tail[q] = PID_W'(p);
  endfunction

  function automatic int dequeue(int q);
    int p;
    if (!q_full[q]) return -1;
    p = q_head[q];
    if (q_tail[q] == p) q_full[q] = 1'b0;
    else q_head[q] = nxt_newer[p];
    return p;
  endfunction

  function automatic void remove_from(int q, int p);
    int o, n;
    if (!q_full[q]) return;
    o = nxt_older[p];
    n = nxt_newer[p];
    if (q_head[q] == p && q_tail[q] == p) q_full[q] = 1'b0;
    else if (q_head[q] == p) q_head[q] = PID_W'(n);
    else if (q_tail[q] == p) q_tail[q] = PID_W'(o);
    else begin
      nxt_newer[o] = PID_W'(n);
      nxt_older[n] = PID_W'(o);
    end
  endfunction

  function automatic bit ready_outranks_running();
    for (int l = 0; l < proc_lv[cur_pid] && l < NUM_LEVELS; l++)
      if (q_full[queue_of(ST_READY, l)]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void reschedule();
    int c, nx, p;
    c = cur_pid;
    nx = 0;
    if (c != 0 && proc_st[c] == ST_RUN) begin
      proc_st[c] = ST_READY;
      enqueue(queue_of(ST_READY, proc_lv[c]), c);
    end
    for (int l = 0; l < NUM_LEVELS; l++) begin
      p = dequeue(queue_of(ST_READY, l));
      if (p >= 0) begin
        nx = p;
        break;
      end
    end
    if (nx != c && proc_st[c] == ST_RUN) proc_st[c] = ST_READY;
    proc_st[nx] = ST_RUN;
    cur_pid = PID_W'(nx);
  endfunction

  function automatic void reset_scheduler();
    cur_pid = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      proc_st[i] = ST_NEW;
      proc_lv[i] = (i == 0) ? LVL_W'(NUM_LEVELS) : LVL_W'(DEFAULT_LEVEL);
    end
    proc_st[0] = ST_RUN;
    for (int q = 0; q < NUM_QUEUES; q++) q_full[q] = 1'b0;
  endfunction

  function automatic sched_result_t schedule_command(logic [MODE_W-1:0] m, int pid,
                                                     int ts, int lv);
    sched_result_t r;
    int  prev, p, s;
    bit  urgent, usr_ok;
    prev = cur_pid;
    r = '0;
    usr_ok = pid != 0;
    case (m)
      MODE_ADMIT: begin
        if (!usr_ok || lv >= NUM_LEVELS || proc_st[pid] != ST_NEW) r.status = 1'b1;
        else begin
          proc_lv[pid] = LVL_W'(lv);
          proc_st[pid] = ST_READY;
          enqueue(queue_of(ST_READY, lv), pid);
          if (ready_outranks_running()) reschedule();
        end
      end
      MODE_BLOCK: begin
        if (cur_pid == 0 || !is_blocked_kind(ts)) r.status = 1'b1;
        else begin
          proc_st[cur_pid] = ST_W'(ts);
          enqueue(queue_of(ts, proc_lv[cur_pid]), cur_pid);
          reschedule();
        end
      end
      MODE_UNBLK_BST: begin
        if (!is_blocked_kind(ts)) r.status = 1'b1;
        else begin
          urgent = 1'b0;
          p = -1;
          for (int l = 0; l < proc_lv[cur_pid] && l < NUM_LEVELS; l++)
            if (q_full[queue_of(ts, l)]) urgent = 1'b1;
          for (int l = 0; l < NUM_LEVELS && p < 0; l++) p = dequeue(queue_of(ts, l));
          if (p >= 0) begin
            proc_st[p] = ST_READY;
            enqueue(queue_of(ST_READY, proc_lv[p]), p);
            if (urgent) reschedule();
          end
        end
      end
      MODE_UNBLK_PID: begin
        if (!usr_ok || !is_blocked_kind(ts)) r.status = 1'b1;
        else if (proc_st[pid] == ts) begin
          remove_from(queue_of(ts, proc_lv[pid]), pid);
          proc_st[pid] = ST_READY;
          enqueue(queue_of(ST_READY, proc_lv[pid]), pid);
          if (proc_lv[pid] < proc_lv[cur_pid]) reschedule();
        end
      end
      MODE_YIELD: reschedule();
      MODE_SET_PRIO: begin
        if (pid == 0 && lv == NUM_LEVELS) begin
        end else if (!usr_ok || lv >= NUM_LEVELS) r.status = 1'b1;
        else begin
          s = proc_st[pid];
          if (pid != cur_pid && s != ST_NEW && s != ST_RUN) begin
            remove_from(queue_of(s, proc_lv[pid]), pid);
            enqueue(queue_of(s, lv), pid);
          end
          proc_lv[pid] = LVL_W'(lv);
          if (ready_outranks_running()) reschedule();
        end
      end
      MODE_READ_PRIO: r.read_level = proc_lv[pid];
      default: r.status = 1'b1;
    endcase
    r.running_pid = cur_pid;
    r.switched = cur_pid != prev;
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_command(logic [MODE_W-1:0] m, int pid, int ts, int lv);
    mode_i = m;
    pid_i = PID_W'(pid);
    target_state_i = ST_W'(ts);
    level_i = LVL_W'(lv);
    start = 1'b1;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    expected_results.push_back(schedule_command(m, pid, ts, lv));
    @(negedge clk_i);
    start = 1'b0;
    if (idling_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 14)) @(negedge clk_i);
  endtask

  task automatic send_random_command();
    logic [MODE_W-1:0] m;
    int pid, ts, lv, pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) m = MODE_ADMIT;
    else if (pick < 33) m = MODE_BLOCK;
    else if (pick < 48) m = MODE_UNBLK_BST;
    else if (pick < 63) m = MODE_UNBLK_PID;
    else if (pick < 75) m = MODE_YIELD;
    else if (pick < 88) m = MODE_SET_PRIO;
    else if (pick < 96) m = MODE_READ_PRIO;
    else m = MODE_W'($urandom_range(0, 7));
    // mostly legal operands, some noise over the full field range
    if ($urandom_range(0, 9) == 0) begin
      pid = $urandom_range(0, 15);
      ts = $urandom_range(0, 7);
      lv = $urandom_range(0, 7);
    end else begin
      pid = $urandom_range(1, NUM_TASKS - 1);
      ts = $urandom_range(3, NUM_STATES - 1);
      lv = $urandom_range(0, NUM_LEVELS - 1);
    end
    send_command(m, pid, ts, lv);
  endtask

  task automatic test_error_cases();
    send_command(MODE_READ_PRIO, 0, 0, 0);
    send_command(MODE_READ_PRIO, 15, 7, 7);
    send_command(MODE_ADMIT, 0, 1, 2);
    send_command(MODE_ADMIT, 3, 1, 4);
    send_command(MODE_BLOCK, 0, 3, 0);
    send_command(MODE_UNBLK_BST, 0, 3, 0);
    send_command(MODE_UNBLK_PID, 4, 2, 0);
    send_command(MODE_UNUSED, 15, 7, 7);
    send_command(MODE_SET_PRIO, 0, 0, NUM_LEVELS);
    send_command(MODE_SET_PRIO, 0, 0, 2);
    send_command(MODE_SET_PRIO, 4, 0, 7);
  endtask

  task automatic test_scheduling();
    send_command(MODE_ADMIT, 5, 0, 3);
    send_command(MODE_ADMIT, 6, 0, 1);
    send_command(MODE_ADMIT, 7, 0, 0);
    send_command(MODE_ADMIT, 7, 0, 0);
    send_command(MODE_BLOCK, 0, 5, 0);
    send_command(MODE_YIELD, 0, 0, 0);
    send_command(MODE_UNBLK_BST, 0, 5, 0);
    send_command(MODE_BLOCK, 0, 3, 0);
    send_command(MODE_UNBLK_PID, 7, 4, 0);
    send_command(MODE_UNBLK_PID, 7, 3, 0);
    send_command(MODE_SET_PRIO, 5, 0, 0);
    send_command(MODE_READ_PRIO, 5, 0, 0);
    send_command(MODE_ADMIT, 15, 0, 3);
    send_command(MODE_BLOCK, 0, 7, 0);
  endtask

  task automatic test_random_traffic(int n);
    repeat (n) send_random_command();
  endtask

  task automatic test_drain_pause();
    wait (expected_results.size() == 0);
    @(negedge clk_i);
    test_random_traffic(50);
  endtask

  task automatic test_back_to_back();
    idling_on = 1'b0;
    test_random_traffic(400);
  endtask

  always @(posedge clk_i) begin
    sched_result_t e;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing pending, running_pid %0d", running_pid_o);
        n_errors++;
      end else begin
        e = expected_results.pop_front();
        if (running_pid_o !== e.running_pid) begin
          $error("running_pid expected %0d actual %0d", e.running_pid, running_pid_o);
          n_errors++;
        end
        if (status_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status_o);
          n_errors++;
        end
        if (read_level_o !== e.read_level) begin
          $error("read_level expected %0d actual %0d", e.read_level, read_level_o);
          n_errors++;
        end
        if (switched_o !== e.switched) begin
          $error("switched expected %0d actual %0d", e.switched, switched_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    reset_scheduler();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_error_cases();
    test_scheduling();
    test_random_traffic(1200);
    test_drain_pause();
    test_back_to_back();
    wait (expected_results.size() == 0);
    repeat (10) @(negedge clk_i);
    if (n_errors == 0 && expected_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
